// ===== design/mdms_pkg.sv =====
// Shared types and constants of the Modbus data model store.
package mdms_pkg;

	localparam int ADDR_W = 16;
	localparam int WORD_W = 16;
	localparam int ACT_W = 3;
	localparam int LANE_W = 3;
	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 8;

	localparam logic [LANE_W-1:0] BIT_INDEX_MASK = 3'h7;
	localparam logic [ADDR_W-1:0] TRIG_ADDR = 16'h000A;
	localparam logic [WORD_W-1:0] TRIG_VALUE = 16'h5AA5;
	localparam logic [WORD_W-1:0] DEV_RESET0 = 16'd1;
	localparam logic [WORD_W-1:0] DEV_RESET1 = 16'd100;
	localparam logic [ADDR_W-1:0] DEV_BASE_RST = 16'h0000;
	localparam logic [ADDR_W-1:0] CTL_BASE_RST = 16'h000A;
	localparam logic [ADDR_W-1:0] STS_BASE_RST = 16'h0040;

	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_BASE = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CONTROL_BASE = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STATUS_BASE = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_UPGRADE_EN = 8'd3;

	localparam logic [ACT_W-1:0] ACT_READ_REG = 3'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE_HOLD = 3'd1;
	localparam logic [ACT_W-1:0] ACT_READ_COIL = 3'd2;
	localparam logic [ACT_W-1:0] ACT_WRITE_COIL = 3'd3;
	localparam logic [ACT_W-1:0] ACT_READ_DISC = 3'd4;
	localparam logic [ACT_W-1:0] ACT_WRITE_DISC = 3'd5;
	localparam logic [ACT_W-1:0] ACT_WRITE_STATUS = 3'd6;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [ADDR_W-1:0] address;
		logic register_kind;
		logic [WORD_W-1:0] write_value;
	} mdms_cmd_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic address_hit;
		logic is_holding_address;
		logic is_input_address;
		logic upgrade_request;
	} mdms_res_t;

	typedef struct packed {
		logic word_rd;
		logic word_wr;
		logic bit_rd;
		logic bit_wr;
		logic hit;
		logic is_hold;
		logic is_inp;
		logic upgrade;
	} mdms_acc_t;

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_READ  = 4'b0100,
		ST_WRITE = 4'b1000
	} mdms_state_t;

endpackage

// ===== design/mdms_access_dec.sv =====
// Region decode of one access: hit flags, memory operation and memory addresses.
module mdms_access_dec #(
	parameter int DEVICE_WORDS = 10,
	parameter int CONTROL_WORDS = 50,
	parameter int STATUS_WORDS = 50,
	parameter int COIL_COUNT = 256,
	parameter int DISCRETE_COUNT = 256,
	localparam int WORD_DEPTH = DEVICE_WORDS + CONTROL_WORDS + STATUS_WORDS,
	localparam int WAW = $clog2(WORD_DEPTH),
	localparam int COIL_ROWS = (COIL_COUNT + 7) / 8,
	localparam int DISC_ROWS = (DISCRETE_COUNT + 7) / 8,
	localparam int BAW = $clog2(COIL_ROWS + DISC_ROWS)
) (
	input  mdms_pkg::mdms_cmd_t cmd,
	input  logic [mdms_pkg::ADDR_W-1:0] device_base,
	input  logic [mdms_pkg::ADDR_W-1:0] control_base,
	input  logic [mdms_pkg::ADDR_W-1:0] status_base,
	input  logic upgrade_en,
	output mdms_pkg::mdms_acc_t acc,
	output logic [WAW-1:0] word_idx,
	output logic [BAW-1:0] bit_row,
	output logic [mdms_pkg::LANE_W-1:0] lane
);
	import mdms_pkg::*;

	logic [ADDR_W-1:0] off_dev, off_ctl, off_sts;
	logic dev_hit, ctl_hit, sts_hit, hold_hit;
	logic coil_in, disc_in;
	logic [WAW-1:0] hold_idx, sts_idx;
	logic [BAW-1:0] row_base;

	assign off_dev = cmd.address - device_base;
	assign off_ctl = cmd.address - control_base;
	assign off_sts = cmd.address - status_base;
	assign dev_hit = (cmd.address >= device_base) && (off_dev < ADDR_W'(DEVICE_WORDS));
	assign ctl_hit = (cmd.address >= control_base) && (off_ctl < ADDR_W'(CONTROL_WORDS));
	assign sts_hit = (cmd.address >= status_base) && (off_sts < ADDR_W'(STATUS_WORDS));
	assign hold_hit = dev_hit || ctl_hit;

	assign hold_idx = dev_hit ? WAW'(off_dev) : WAW'(DEVICE_WORDS) + WAW'(off_ctl);
	assign sts_idx = WAW'(DEVICE_WORDS + CONTROL_WORDS) + WAW'(off_sts);

	assign coil_in = {1'b0, cmd.address} < (ADDR_W+1)'(COIL_COUNT);
	assign disc_in = {1'b0, cmd.address} < (ADDR_W+1)'(DISCRETE_COUNT);
	assign lane = cmd.address[LANE_W-1:0] & BIT_INDEX_MASK;

	always_comb begin
		acc = '0;
		acc.is_hold = hold_hit;
		acc.is_inp = sts_hit;
		word_idx = hold_idx;
		row_base = '0;
		case (cmd.action)
			ACT_READ_REG: begin
				if (cmd.register_kind) begin
					word_idx = sts_idx;
					acc.hit = sts_hit;
				end else begin
					acc.hit = hold_hit;
				end
				acc.word_rd = acc.hit;
			end
			ACT_WRITE_HOLD: begin
				acc.hit = hold_hit;
				acc.word_wr = hold_hit;
				acc.upgrade = upgrade_en && (cmd.address == TRIG_ADDR) &&
					(cmd.write_value == TRIG_VALUE);
			end
			ACT_READ_COIL: begin
				acc.hit = coil_in;
				acc.bit_rd = coil_in;
			end
			ACT_WRITE_COIL: begin
				acc.hit = coil_in;
				acc.bit_wr = coil_in;
			end
			ACT_READ_DISC: begin
				acc.hit = disc_in;
				acc.bit_rd = disc_in;
				row_base = BAW'(COIL_ROWS);
			end
			ACT_WRITE_DISC: begin
				acc.hit = disc_in;
				acc.bit_wr = disc_in;
				row_base = BAW'(COIL_ROWS);
			end
			ACT_WRITE_STATUS: begin
				word_idx = sts_idx;
				acc.hit = sts_hit;
				acc.word_wr = sts_hit;
			end
			default: begin
				acc.hit = 1'b0;
			end
		endcase
	end

	assign bit_row = row_base + BAW'(cmd.address >> LANE_W);

endmodule

// ===== design/modbus_data_model_store.sv =====
// Top level of the Modbus data model store: word and bit memories with read-modify-write control.
//
// Channel  | Handshake                  | Payload
// command  | start, busy                | cmd (action, address, register_kind, write_value)
// result   | done (one-cycle strobe)    | result (read_data, flags, upgrade_request)
// config   | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// A transaction is accepted when start is high and busy is low; it is latched and decoded,
// the memories are read, then the data is modified and written back, and done strobes with
// the result. The next transaction can be accepted in the cycle that shows the result, so
// transactions do not overlap, owing to the single-port read-then-write of the word and bit
// memories. After reset a clearing pass over max(DEVICE_WORDS+CONTROL_WORDS+STATUS_WORDS,
// bit rows) addresses keeps busy high.
// The receiver cannot stall; configuration writes are always taken.
module modbus_data_model_store #(
	parameter int DEVICE_WORDS = 10,
	parameter int CONTROL_WORDS = 50,
	parameter int STATUS_WORDS = 50,
	parameter int COIL_COUNT = 256,
	parameter int DISCRETE_COUNT = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  mdms_pkg::mdms_cmd_t cmd,
	output logic done,
	output mdms_pkg::mdms_res_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [mdms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mdms_pkg::WORD_W-1:0] cfg_data
);
	import mdms_pkg::*;

	localparam int WORD_DEPTH = DEVICE_WORDS + CONTROL_WORDS + STATUS_WORDS;
	localparam int WAW = $clog2(WORD_DEPTH);
	localparam int COIL_ROWS = (COIL_COUNT + 7) / 8;
	localparam int DISC_ROWS = (DISCRETE_COUNT + 7) / 8;
	localparam int BIT_DEPTH = COIL_ROWS + DISC_ROWS;
	localparam int BAW = $clog2(BIT_DEPTH);
	localparam int CLR_DEPTH = (WORD_DEPTH > BIT_DEPTH) ? WORD_DEPTH : BIT_DEPTH;
	localparam int CIW = $clog2(CLR_DEPTH);

	mdms_state_t state_q;
	logic [CIW-1:0] clr_q;
	logic [ADDR_W-1:0] device_base_q, control_base_q, status_base_q;
	logic upgrade_en_q;

	mdms_acc_t acc_d, acc_q;
	logic [WAW-1:0] word_idx_d, word_idx_q;
	logic [BAW-1:0] bit_row_d, bit_row_q;
	logic [LANE_W-1:0] lane_d, lane_q;
	logic [WORD_W-1:0] wval_q;

	logic [WORD_W-1:0] wmem [WORD_DEPTH];
	logic [BYTE_W-1:0] bmem [BIT_DEPTH];
	logic [WORD_W-1:0] wrd_q;
	logic [BYTE_W-1:0] brd_q;

	logic wmem_we, bmem_we;
	logic [WAW-1:0] wmem_wa;
	logic [BAW-1:0] bmem_wa;
	logic [WORD_W-1:0] wmem_wd, clr_word;
	logic [BYTE_W-1:0] bmem_wd, new_byte;
	logic clr_in_word, clr_in_bit, accept;
	logic done_q;
	mdms_res_t result_q;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign result = result_q;

	mdms_access_dec #(
		.DEVICE_WORDS(DEVICE_WORDS),
		.CONTROL_WORDS(CONTROL_WORDS),
		.STATUS_WORDS(STATUS_WORDS),
		.COIL_COUNT(COIL_COUNT),
		.DISCRETE_COUNT(DISCRETE_COUNT)
	) u_dec (
		.cmd(cmd),
		.device_base(device_base_q),
		.control_base(control_base_q),
		.status_base(status_base_q),
		.upgrade_en(upgrade_en_q),
		.acc(acc_d),
		.word_idx(word_idx_d),
		.bit_row(bit_row_d),
		.lane(lane_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_base_q <= DEV_BASE_RST;
			control_base_q <= CTL_BASE_RST;
			status_base_q <= STS_BASE_RST;
			upgrade_en_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEVICE_BASE: device_base_q <= cfg_data;
				REG_CONTROL_BASE: control_base_q <= cfg_data;
				REG_STATUS_BASE: status_base_q <= cfg_data;
				REG_UPGRADE_EN: upgrade_en_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CIW'(CLR_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q <= acc_d;
			word_idx_q <= word_idx_d;
			bit_row_q <= bit_row_d;
			lane_q <= lane_d;
			wval_q <= cmd.write_value;
		end
		if (state_q == ST_WRITE) begin
			result_q.address_hit <= acc_q.hit;
			result_q.is_holding_address <= acc_q.is_hold;
			result_q.is_input_address <= acc_q.is_inp;
			result_q.upgrade_request <= acc_q.upgrade;
			if (acc_q.word_rd) begin
				result_q.read_data <= wrd_q;
			end else if (acc_q.bit_rd) begin
				result_q.read_data <= {{(WORD_W-1){1'b0}}, brd_q[lane_q]};
			end else begin
				result_q.read_data <= '0;
			end
		end
	end

	assign clr_in_word = {1'b0, clr_q} < (CIW+1)'(WORD_DEPTH);
	assign clr_in_bit = {1'b0, clr_q} < (CIW+1)'(BIT_DEPTH);

	always_comb begin
		clr_word = '0;
		if (clr_q == '0) begin
			clr_word = DEV_RESET0;
		end else if ((DEVICE_WORDS > 1) && (clr_q == CIW'(1))) begin
			clr_word = DEV_RESET1;
		end
	end

	always_comb begin
		new_byte = brd_q;
		new_byte[lane_q] = (wval_q != '0);
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			wmem_we = clr_in_word;
			wmem_wa = WAW'(clr_q);
			wmem_wd = clr_word;
			bmem_we = clr_in_bit;
			bmem_wa = BAW'(clr_q);
			bmem_wd = '0;
		end else begin
			wmem_we = (state_q == ST_WRITE) && acc_q.word_wr;
			wmem_wa = word_idx_q;
			wmem_wd = wval_q;
			bmem_we = (state_q == ST_WRITE) && acc_q.bit_wr;
			bmem_wa = bit_row_q;
			bmem_wd = new_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (wmem_we) begin
			wmem[wmem_wa] <= wmem_wd;
		end
		if (state_q == ST_READ) begin
			wrd_q <= wmem[word_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (bmem_we) begin
			bmem[bmem_wa] <= bmem_wd;
		end
		if (state_q == ST_READ) begin
			brd_q <= bmem[bit_row_q];
		end
	end

	a_done_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_WRITE))
		else $error("Result strobe without a preceding write-back cycle.");

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_READ))
		else $error("Accepted transaction did not start a memory read.");

	a_no_write_when_busy_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (!wmem_we && !bmem_we))
		else $error("Memory written during the read cycle of a transaction.");

	a_data_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.read_data != '0)) |-> result.address_hit)
		else $error("Nonzero read data on a missed access.");

endmodule
